[hw/rtl/ddnp_pkg.sv]
// ----------------------------------------------------------------------------
// ddnp_pkg: shared types and constants of the delimited decimal parser
// Result kinds, byte classes, the front-to-back queue entry and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package ddnp_pkg;

   // register map of the configuration port
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_A        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_B        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_C        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_D        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_ENABLE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBERS_WANTED = 3'd5;

   // delimiter registers that the register map can reach
   localparam int NUM_DELIM_REGS = 4;
   localparam logic [7:0] DELIM_RESET [NUM_DELIM_REGS] = '{8'd32, 8'd9, 8'd44, 8'd59};
   localparam logic [NUM_DELIM_REGS-1:0] DELIM_ENABLE_RESET = 4'd1;
   localparam logic [7:0] NUMBERS_WANTED_RESET = 8'd1;

   // special bytes
   localparam logic [7:0] NL_BYTE   = 8'd10;
   localparam logic [7:0] CHAR_ZERO = 8'd48;
   localparam logic [7:0] CHAR_NINE = 8'd57;

   localparam int NUMBER_W = 31;
   localparam logic [NUMBER_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      KIND_VALUE   = 3'd0,
      KIND_DONE    = 3'd1,
      KIND_BLANK   = 3'd2,
      KIND_NOT_NUM = 3'd3,
      KIND_TOO_FEW = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CLS_NEWLINE = 2'd0,
      CLS_DELIM   = 2'd1,
      CLS_DIGIT   = 2'd2,
      CLS_OTHER   = 2'd3
   } byte_class_type;

   typedef struct packed {
      byte_class_type cls;
      logic [3:0]     digit;
   } queue_entry_type;

   typedef struct packed {
      kind_type            kind;
      logic [NUMBER_W-1:0] number;
      logic                saturated;
      logic                last;
   } rsp_item_type;

endpackage

`default_nettype wire

[hw/rtl/ddnp_if.sv]
// ----------------------------------------------------------------------------
// ddnp_if: channel interfaces of the delimited decimal parser
// Byte request channel, result channel and register write channel, each
// with valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface ddnp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [30:0] number;
   logic        saturated;
   logic        last;

   modport source (output valid, output kind, output number, output saturated,
                   output last, input ready);
   modport sink   (input valid, input kind, input number, input saturated,
                   input last, output ready);
endinterface

interface ddnp_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/ddnp_queue.sv]
// ----------------------------------------------------------------------------
// ddnp_queue: short queue between the classifier and the token engine
// Two-entry register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddnp_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   output      logic                     push_ready,
   input  wire ddnp_pkg::queue_entry_type push_data,
   output      logic                     pop_valid,
   input  wire logic                     pop_ready,
   output      ddnp_pkg::queue_entry_type pop_data
);
   import ddnp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type   mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/ddnp_front.sv]
// ----------------------------------------------------------------------------
// ddnp_front: register file and byte classifier
// Holds the configuration registers and sorts each request byte into
// newline, delimiter, digit or other before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ddnp_front #(
   parameter int NUM_DELIMS = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   ddnp_req_if.sink                      req_bus,
   ddnp_csr_if.sink                      csr_bus,
   output      logic                     push_valid,
   input  wire logic                     push_ready,
   output      ddnp_pkg::queue_entry_type push_data,
   output      logic [7:0]               numbers_wanted
);
   import ddnp_pkg::*;

   localparam int ACTIVE_DELIMS = (NUM_DELIMS < NUM_DELIM_REGS) ? NUM_DELIMS : NUM_DELIM_REGS;

   logic [7:0]                delim_ff [ACTIVE_DELIMS];
   logic [NUM_DELIM_REGS-1:0] delim_enable_ff;
   logic [7:0]                numbers_wanted_ff;
   logic                      csr_fire;
   logic                      delim_hit;
   logic [7:0]                digit_offset;

   assign csr_bus.ready  = 1'b1;
   assign csr_fire       = csr_bus.valid;
   assign numbers_wanted = numbers_wanted_ff;

   // delimiter registers
   for (genvar g = 0; g < ACTIVE_DELIMS; g++) begin : g_delim
      always_ff @(posedge clock) begin
         if (reset) begin
            delim_ff[g] <= DELIM_RESET[g];
         end else if (csr_fire && csr_bus.index == CSR_INDEX_W'(g)) begin
            delim_ff[g] <= csr_bus.data;
         end
      end
   end

   // enable mask and wanted count
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_enable_ff   <= DELIM_ENABLE_RESET;
         numbers_wanted_ff <= NUMBERS_WANTED_RESET;
      end else if (csr_fire) begin
         if (csr_bus.index == CSR_DELIM_ENABLE) begin
            delim_enable_ff <= csr_bus.data[NUM_DELIM_REGS-1:0];
         end
         if (csr_bus.index == CSR_NUMBERS_WANTED) begin
            numbers_wanted_ff <= csr_bus.data;
         end
      end
   end

   // delimiter match over the enabled registers
   always_comb begin
      delim_hit = 1'b0;
      for (int i = 0; i < ACTIVE_DELIMS; i++) begin
         if (delim_enable_ff[i] && delim_ff[i] == req_bus.ch) begin
            delim_hit = 1'b1;
         end
      end
   end

   // classify the byte; newline wins over any delimiter match
   assign digit_offset = req_bus.ch - CHAR_ZERO;

   always_comb begin
      push_data.digit = digit_offset[3:0];
      if (req_bus.ch == NL_BYTE) begin
         push_data.cls = CLS_NEWLINE;
      end else if (delim_hit) begin
         push_data.cls = CLS_DELIM;
      end else if (req_bus.ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
         push_data.cls = CLS_DIGIT;
      end else begin
         push_data.cls = CLS_OTHER;
      end
   end

   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

endmodule

`default_nettype wire

[hw/rtl/ddnp_back.sv]
// ----------------------------------------------------------------------------
// ddnp_back: token engine and result stage
// Tracks the open token and the line, accumulates decimal values with
// clamping, and issues up to two results per byte through an output
// register and a second-result holding register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddnp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     pop_valid,
   output      logic                     pop_ready,
   input  wire ddnp_pkg::queue_entry_type pop_data,
   input  wire logic [7:0]               numbers_wanted,
   ddnp_rsp_if.source                    rsp_bus
);
   import ddnp_pkg::*;

   // line and token state
   logic                in_token_ff,      in_token_in;
   logic                token_bad_ff,     token_bad_in;
   logic                token_sat_ff,     token_sat_in;
   logic [NUMBER_W-1:0] accum_ff,         accum_in;
   logic [7:0]          parsed_count_ff,  parsed_count_in;
   logic                line_nonblank_ff, line_nonblank_in;
   logic                line_failed_ff,   line_failed_in;

   // result registers
   logic                out_valid_ff,  out_valid_in;
   rsp_item_type        out_ff,        out_in;
   logic                pend_valid_ff, pend_valid_in;
   rsp_item_type        pend_ff,       pend_in;

   logic                take;
   logic                out_taken;
   logic [1:0]          result_count;
   rsp_item_type        res0;
   rsp_item_type        res1;
   rsp_item_type        close_item;
   rsp_item_type        outcome_item;
   logic [7:0]          count_after;
   logic                fail_after;
   logic                starting;
   logic [NUMBER_W-1:0] base;
   logic [NUMBER_W+3:0] prod;
   logic                overflow;

   assign out_taken = out_valid_ff && rsp_bus.ready;
   assign pop_ready = !pend_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign take      = pop_valid && pop_ready;

   // value of the open token as a result
   always_comb begin
      close_item = '0;
      if (token_bad_ff) begin
         close_item.kind = KIND_NOT_NUM;
      end else begin
         close_item.kind      = KIND_VALUE;
         close_item.number    = accum_ff;
         close_item.saturated = token_sat_ff;
      end
   end

   // decimal step: accum * 10 + digit, clamped
   assign starting = !in_token_ff;
   assign base     = starting ? '0 : accum_ff;
   assign prod     = {1'b0, base, 3'b000} + {3'b000, base, 1'b0}
                   + {{NUMBER_W{1'b0}}, pop_data.digit};
   assign overflow = |prod[NUMBER_W+3:NUMBER_W];

   // line outcome at newline
   assign count_after = parsed_count_ff + {7'b0, in_token_ff && !token_bad_ff};
   assign fail_after  = in_token_ff && token_bad_ff;

   always_comb begin
      outcome_item = '0;
      if (!line_nonblank_ff) begin
         outcome_item.kind = KIND_BLANK;
      end else if (count_after >= numbers_wanted) begin
         outcome_item.kind = KIND_DONE;
      end else begin
         outcome_item.kind = KIND_TOO_FEW;
      end
   end

   // per-byte state update and results
   always_comb begin
      in_token_in      = in_token_ff;
      token_bad_in     = token_bad_ff;
      token_sat_in     = token_sat_ff;
      accum_in         = accum_ff;
      parsed_count_in  = parsed_count_ff;
      line_nonblank_in = line_nonblank_ff;
      line_failed_in   = line_failed_ff;
      result_count     = 2'd0;
      res0             = '0;
      res1             = '0;
      case (pop_data.cls)
         CLS_NEWLINE: begin
            if (!line_failed_ff) begin
               if (in_token_ff) begin
                  res0         = close_item;
                  result_count = 2'd1;
               end
               if (!fail_after) begin
                  if (in_token_ff) begin
                     res1         = outcome_item;
                     result_count = 2'd2;
                  end else begin
                     res0         = outcome_item;
                     result_count = 2'd1;
                  end
               end
            end
            in_token_in      = 1'b0;
            token_bad_in     = 1'b0;
            token_sat_in     = 1'b0;
            accum_in         = '0;
            parsed_count_in  = '0;
            line_nonblank_in = 1'b0;
            line_failed_in   = 1'b0;
         end
         CLS_DELIM: begin
            if (!line_failed_ff && in_token_ff) begin
               res0         = close_item;
               result_count = 2'd1;
               in_token_in  = 1'b0;
               if (token_bad_ff) begin
                  line_failed_in = 1'b1;
               end else begin
                  parsed_count_in = parsed_count_ff + 8'd1;
               end
            end
         end
         CLS_DIGIT, CLS_OTHER: begin
            if (!line_failed_ff) begin
               line_nonblank_in = 1'b1;
               if (parsed_count_ff < numbers_wanted) begin
                  in_token_in = 1'b1;
                  if (starting) begin
                     token_bad_in = 1'b0;
                     token_sat_in = 1'b0;
                     accum_in     = '0;
                  end
                  if (pop_data.cls == CLS_DIGIT) begin
                     if (overflow) begin
                        accum_in     = VALUE_MAX;
                        token_sat_in = 1'b1;
                     end else begin
                        accum_in = prod[NUMBER_W-1:0];
                     end
                  end else begin
                     token_bad_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            result_count = 2'd0;
         end
      endcase
      res0.last = (result_count == 2'd1);
      res1.last = 1'b1;
   end

   // result stage: output register plus holding register for a second result
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (take) begin
         out_valid_in = (result_count != 2'd0);
         out_in       = res0;
         if (result_count == 2'd2) begin
            pend_valid_in = 1'b1;
            pend_in       = res1;
         end
      end else if (pend_valid_ff && out_taken) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         pend_valid_in = 1'b0;
      end else if (out_taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff      <= 1'b0;
         token_bad_ff     <= 1'b0;
         token_sat_ff     <= 1'b0;
         accum_ff         <= '0;
         parsed_count_ff  <= '0;
         line_nonblank_ff <= 1'b0;
         line_failed_ff   <= 1'b0;
         out_valid_ff     <= 1'b0;
         pend_valid_ff    <= 1'b0;
      end else begin
         if (take) begin
            in_token_ff      <= in_token_in;
            token_bad_ff     <= token_bad_in;
            token_sat_ff     <= token_sat_in;
            accum_ff         <= accum_in;
            parsed_count_ff  <= parsed_count_in;
            line_nonblank_ff <= line_nonblank_in;
            line_failed_ff   <= line_failed_in;
         end
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.kind      = out_ff.kind;
   assign rsp_bus.number    = out_ff.number;
   assign rsp_bus.saturated = out_ff.saturated;
   assign rsp_bus.last      = out_ff.last;

endmodule

`default_nettype wire

[hw/rtl/delimited_decimal_number_parser.sv]
// ----------------------------------------------------------------------------
// delimited_decimal_number_parser: streaming decimal token parser
// Text bytes arrive on the request channel; each request is one byte.
// Enabled delimiter bytes split a line into tokens and newline ends it.
// The first numbers_wanted tokens come out on the response channel as
// values (kind 0, clamped at 2147483647 with saturated set); a token with
// a non-digit gives a not-numerical result and silences the rest of the
// line. Newline gives line done, blank line or too few values.
// Registers are written over the csr channel (always ready) while idle;
// the user keeps to this, the block itself does not enforce it. One
// request per cycle while responses flow; a byte that yields two
// responses (newline closing a token) holds the token engine until its
// second response is in the output register. A two-entry queue sits
// between classifier and token engine, so the request side keeps going
// for two bytes while responses stall, then req_bus.ready drops until
// the response side moves again. Reset restores the register defaults,
// empties the queue and starts a fresh line.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_decimal_number_parser #(
   parameter int NUM_DELIMS = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   ddnp_req_if.sink   req_bus,
   ddnp_rsp_if.source rsp_bus,
   ddnp_csr_if.sink   csr_bus
);
   import ddnp_pkg::*;

   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_data;
   logic            pop_valid;
   logic            pop_ready;
   queue_entry_type pop_data;
   logic [7:0]      numbers_wanted;

   // classifier and register file
   ddnp_front #(
      .NUM_DELIMS (NUM_DELIMS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .csr_bus        (csr_bus),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data),
      .numbers_wanted (numbers_wanted)
   );

   // decoupling queue
   ddnp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // token engine and responses
   ddnp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .numbers_wanted (numbers_wanted),
      .rsp_bus        (rsp_bus)
   );

endmodule

`default_nettype wire

[verif/tb_delimited_decimal_number_parser.sv]
// ----------------------------------------------------------------------------
// tb_delimited_decimal_number_parser: self-checking bench for the text parser
// Feeds text bytes through the request channel and keeps a cycle-free model
// of the line and token state in the bench. Every accepted byte queues the
// responses it should cause, and the monitor checks each response field by
// field. The bench opens with a short directed set of lines, then runs
// random phases under different delimiter and count settings. Both sides
// stall at random, and one long receiver stall backs the parser up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_delimited_decimal_number_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import ddnp_pkg::*;

   localparam int PHASE_BYTES = 231;
   localparam int RANDOM_PHASES = 8;
   localparam int LONG_STALL_AT = 500;
   localparam int LONG_STALL_CYCLES = 120;
   localparam int LONG_STALL_BACKLOG = 16;
   localparam logic [7:0] COMMON_SEPS [8] = '{8'd32, 8'd9, 8'd44, 8'd59,
                                              8'd58, 8'd124, 8'd47, 8'd45};

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddnp_req_if req_bus ();
   ddnp_rsp_if rsp_bus ();
   ddnp_csr_if csr_bus ();

   delimited_decimal_number_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // register copies
   logic [7:0]                delim_char [NUM_DELIM_REGS];
   logic [NUM_DELIM_REGS-1:0] delim_mask;
   logic [7:0]                values_needed;

   // line and token state
   logic                tok_open;
   logic                tok_bad;
   logic                tok_clamped;
   logic [NUMBER_W-1:0] tok_value;
   logic [7:0]          values_seen;
   logic                line_has_text;
   logic                line_dead;

   logic [7:0]   pending_bytes [$];
   rsp_item_type predicted_rsp [$];
   rsp_item_type next_rsp;

   int bytes_taken = 0;
   int mismatches = 0;
   int cfg_writes = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int send_gap = 0;
   int stall_left = 0;
   bit req_took = 1'b0;
   bit long_stall_done = 1'b0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_separator(input logic [7:0] c);
      int i;
      for (i = 0; i < NUM_DELIM_REGS; i++)
         if (delim_mask[i] && delim_char[i] == c)
            return 1'b1;
      return 1'b0;
   endfunction

   // ends the open token: its value, or the not-numerical error
   function automatic rsp_item_type finish_token();
      rsp_item_type r;
      r = '0;
      if (tok_bad) begin
         r.kind = KIND_NOT_NUM;
         line_dead = 1'b1;
      end else begin
         r.kind = KIND_VALUE;
         r.number = tok_value;
         r.saturated = tok_clamped;
         values_seen = values_seen + 8'd1;
      end
      tok_open = 1'b0;
      return r;
   endfunction

   // advances the line state by one byte and queues the responses it causes
   function automatic void parse_byte(input logic [7:0] c);
      rsp_item_type outs [$];
      rsp_item_type r;
      logic [63:0]  grown;
      if (c == NL_BYTE) begin
         if (!line_dead) begin
            if (tok_open)
               outs = {outs, finish_token()};
            if (!line_dead) begin
               r = '0;
               if (!line_has_text)
                  r.kind = KIND_BLANK;
               else if (values_seen >= values_needed)
                  r.kind = KIND_DONE;
               else
                  r.kind = KIND_TOO_FEW;
               outs = {outs, r};
            end
         end
         tok_open = 1'b0;
         tok_bad = 1'b0;
         tok_clamped = 1'b0;
         tok_value = '0;
         values_seen = '0;
         line_has_text = 1'b0;
         line_dead = 1'b0;
      end else if (!line_dead) begin
         if (is_separator(c)) begin
            if (tok_open)
               outs = {outs, finish_token()};
         end else begin
            line_has_text = 1'b1;
            // tokens past the wanted count are dropped
            if (values_seen < values_needed) begin
               if (!tok_open) begin
                  tok_open = 1'b1;
                  tok_bad = 1'b0;
                  tok_clamped = 1'b0;
                  tok_value = '0;
               end
               if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                  grown = 64'(tok_value) * 64'd10 + 64'(c - CHAR_ZERO);
                  if (grown > 64'(VALUE_MAX)) begin
                     grown = 64'(VALUE_MAX);
                     tok_clamped = 1'b1;
                  end
                  tok_value = grown[NUMBER_W-1:0];
               end else begin
                  tok_bad = 1'b1;
               end
            end
         end
      end
      if (outs.size() != 0)
         outs[outs.size()-1].last = 1'b1;
      predicted_rsp = {predicted_rsp, outs};
   endfunction

   // monitor: accepted requests, responses and register writes
   always @(posedge clock) begin
      if (reset) begin
         foreach (delim_char[i])
            delim_char[i] = DELIM_RESET[i];
         delim_mask = DELIM_ENABLE_RESET;
         values_needed = NUMBERS_WANTED_RESET;
         tok_open = 1'b0;
         tok_bad = 1'b0;
         tok_clamped = 1'b0;
         tok_value = '0;
         values_seen = '0;
         line_has_text = 1'b0;
         line_dead = 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_DELIM_A, CSR_DELIM_B, CSR_DELIM_C, CSR_DELIM_D:
                  delim_char[csr_bus.index[1:0]] = csr_bus.data;
               CSR_DELIM_ENABLE: delim_mask = csr_bus.data[NUM_DELIM_REGS-1:0];
               CSR_NUMBERS_WANTED: values_needed = csr_bus.data;
               default: ;
            endcase
            cfg_writes++;
         end
         if (req_bus.valid && req_bus.ready) begin
            parse_byte(req_bus.ch);
            void'(pending_bytes.pop_front());
            bytes_taken++;
            req_took = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: kind %0d number %0d sat %0b last %0b",
                           rsp_bus.kind, rsp_bus.number, rsp_bus.saturated, rsp_bus.last);
            end else begin
               next_rsp = predicted_rsp.pop_front();
               if (rsp_bus.kind !== next_rsp.kind || rsp_bus.number !== next_rsp.number ||
                   rsp_bus.saturated !== next_rsp.saturated ||
                   rsp_bus.last !== next_rsp.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: got kind %0d number %0d sat %0b last %0b, %s %0d %0d %0b %0b",
                              rsp_bus.kind, rsp_bus.number, rsp_bus.saturated,
                              rsp_bus.last, "expected", next_rsp.kind, next_rsp.number,
                              next_rsp.saturated, next_rsp.last);
               end
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.ch <= '0;
      end else if (req_bus.valid && !req_took) begin
         // request still waiting for ready, hold it
      end else if (send_gap > 0) begin
         send_gap--;
         req_bus.valid <= 1'b0;
      end else if (pending_bytes.size() != 0 && send_idle_pct != 0 &&
                   $urandom_range(0, 99) < send_idle_pct) begin
         send_gap = $urandom_range(0, 5);
         req_bus.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
         req_bus.valid <= 1'b1;
         req_bus.ch <= pending_bytes[0];
      end else begin
         req_bus.valid <= 1'b0;
      end
      req_took = 1'b0;
   end

   // response receiver, with one long hold-off to back the parser up
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!long_stall_done && bytes_taken >= LONG_STALL_AT &&
                   pending_bytes.size() >= LONG_STALL_BACKLOG) begin
         long_stall_done = 1'b1;
         stall_left = LONG_STALL_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
         stall_left = $urandom_range(0, 5);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      int seen;
      seen = cfg_writes;
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(negedge clock); while (cfg_writes == seen);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                             input logic [7:0] d, input logic [7:0] mask,
                             input logic [7:0] wanted);
      write_reg(CSR_DELIM_A, a);
      write_reg(CSR_DELIM_B, b);
      write_reg(CSR_DELIM_C, c);
      write_reg(CSR_DELIM_D, d);
      write_reg(CSR_DELIM_ENABLE, mask);
      write_reg(CSR_NUMBERS_WANTED, wanted);
   endtask

   // all requests taken, all responses back, then let the pipe settle
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || predicted_rsp.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         pending_bytes = {pending_bytes, 8'(s[i])};
   endtask

   function automatic logic [7:0] random_delim();
      if ($urandom_range(0, 9) < 7)
         return COMMON_SEPS[$urandom_range(0, 7)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] random_non_newline();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == NL_BYTE);
      return b;
   endfunction

   // one random line: mostly delimited digit tokens, sometimes noise
   task automatic queue_line();
      logic [7:0] seps [$];
      logic [7:0] tok [$];
      int i, t, n_tok, len, roll;
      for (i = 0; i < NUM_DELIM_REGS; i++)
         if (delim_mask[i] && delim_char[i] != NL_BYTE)
            seps = {seps, delim_char[i]};
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         len = $urandom_range(0, 12);
         repeat (len) pending_bytes = {pending_bytes, random_non_newline()};
      end else begin
         n_tok = $urandom_range(0, (values_needed > 5) ? 7 : values_needed + 2);
         if (seps.size() != 0 && $urandom_range(0, 4) == 0)
            pending_bytes = {pending_bytes, seps[$urandom_range(0, seps.size() - 1)]};
         for (t = 0; t < n_tok; t++) begin
            roll = $urandom_range(0, 99);
            len = (roll < 80) ? $urandom_range(1, 4) :
                  (roll < 95) ? $urandom_range(5, 9) : $urandom_range(10, 13);
            tok.delete();
            repeat (len) tok = {tok, 8'(CHAR_ZERO + 8'($urandom_range(0, 9)))};
            if ($urandom_range(0, 99) < 8)
               tok[$urandom_range(0, len - 1)] = random_non_newline();
            pending_bytes = {pending_bytes, tok};
            if (seps.size() != 0 && (t < n_tok - 1 || $urandom_range(0, 4) == 0))
               repeat ($urandom_range(1, 2))
                  pending_bytes = {pending_bytes, seps[$urandom_range(0, seps.size() - 1)]};
         end
      end
      pending_bytes = {pending_bytes, NL_BYTE};
   endtask

   // main sequence
   initial begin
      int p, n, s0;
      req_bus.valid = 1'b0;
      req_bus.ch = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed lines under the reset settings
      queue_text("\n");
      queue_text(" \n");
      queue_text("x 2\n");
      queue_text("1 2\n");
      queue_text("9999999999\n");
      wait_idle();

      // newline held in a delimiter register, two values wanted
      set_config(NL_BYTE, 8'd44, 8'd0, 8'd255, 8'd15, 8'd2);
      queue_text("5\n");
      wait_idle();

      // no values wanted
      set_config(8'd32, 8'd9, 8'd44, 8'd59, 8'd1, 8'd0);
      queue_text("4\n");
      wait_idle();

      // random phases
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: set_config(8'd32, 8'd9, 8'd44, 8'd59, 8'd15, 8'd3);
            1: set_config(8'd0, 8'd255, 8'd0, 8'd255, 8'd15, 8'd255);
            2: set_config(8'd32, 8'd44, 8'd9, 8'd59, 8'd0, 8'd1);
            default: set_config(random_delim(), random_delim(), random_delim(),
                                random_delim(), 8'($urandom_range(0, 15)),
                                8'($urandom_range(1, 6)));
         endcase
         send_idle_pct = (p == RANDOM_PHASES - 1 || p % 3 == 0) ? 0 : 25;
         recv_idle_pct = (p == RANDOM_PHASES - 1 || p % 2 == 0) ? 0 : 30;
         n = 0;
         while (n < PHASE_BYTES) begin
            s0 = pending_bytes.size();
            queue_line();
            n += pending_bytes.size() - s0;
         end
         wait_idle();
      end

      repeat (20) @(negedge clock);
      if (predicted_rsp.size() != 0)
         $display("%0d responses never arrived", predicted_rsp.size());
      if (mismatches == 0 && predicted_rsp.size() == 0)
         $display("PASS delimited_decimal_number_parser");
      else
         $display("FAIL delimited_decimal_number_parser");
      $finish;
   end

   // run time limit
   initial begin
      #3000000;
      $display("timeout with %0d requests taken", bytes_taken);
      $display("FAIL delimited_decimal_number_parser");
      $finish;
   end

endmodule

`default_nettype wire
